### rtl/dbc_pkg.sv
package dbc_pkg;

	localparam int WORD_W  = 32;
	localparam int FRAC_W  = 28;
	localparam int SQM_W   = 36;
	localparam int XMIN_W  = 38;
	localparam int SUM4_W  = 38;
	localparam int XY_W    = 33;
	localparam int S_W     = 40;
	localparam int NB_W    = 40;
	localparam int NM_W    = 38;

	localparam int RAD_W   = 90;
	localparam int ROOT_W  = 45;
	localparam int REM_W   = 49;
	localparam int SQ_STAGES = ROOT_W;

	localparam int D_W     = 31;
	localparam int DREM_W  = D_W + 1;
	localparam int Q_W     = 52;
	localparam int PRE_SH  = Q_W - FRAC_W;
	localparam int DIV_STAGES = Q_W;

	localparam int MAG_W   = 53;
	localparam int VAL_W   = 62;
	localparam int SAT_LSB = 45;
	localparam int MH_W    = 22;
	localparam int ML_W    = 23;
	localparam int PSUM_W  = 90;
	localparam int SQR_STAGES = 2;
	localparam int Y_W     = 63;
	localparam int PB_W    = 52;

	localparam int I_DIV_OUT = SQ_STAGES + DIV_STAGES;
	localparam int I_S3      = I_DIV_OUT + 1;
	localparam int I_SQ1_OUT = I_DIV_OUT + SQR_STAGES;
	localparam int I_S4      = I_SQ1_OUT + 1;
	localparam int I_ROOT2   = I_S4 + SQ_STAGES;
	localparam int I_S6      = I_ROOT2 + 1 + SQR_STAGES + 1;
	localparam int EM_LEN    = I_ROOT2 - I_S3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PARENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASS_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASS_B = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASS_C = 2'd3;

	localparam logic [WORD_W-1:0] RST_PARENT = 32'd500589149;
	localparam logic [WORD_W-1:0] RST_MASS_A = 32'd133577244;
	localparam logic [WORD_W-1:0] RST_MASS_B = 32'd37465582;
	localparam logic [WORD_W-1:0] RST_MASS_C = 32'd37465582;

	localparam logic [VAL_W-1:0] VAL_CAP = {VAL_W{1'b1}};
	localparam logic [PB_W-1:0]  ROOT_CAP = {PB_W{1'b1}};

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_st_t;

	typedef struct packed {
		logic [Q_W-1:0]    num;
		logic [DREM_W-1:0] rem;
		logic [Q_W-1:0]    quo;
		logic [D_W-1:0]    den;
	} div_st_t;

	typedef struct packed {
		logic first;
		logic go;
		logic sgn_b;
		logic sgn_c;
	} side_t;

	typedef struct packed {
		logic [NM_W-1:0] nb;
		logic [NM_W-1:0] nc;
	} nmag_t;

	typedef struct packed {
		logic ok;
		logic cap_b;
		logic cap_c;
	} flag_t;

endpackage

### rtl/dbc_sqrt.sv
module dbc_sqrt
	import dbc_pkg::*;
(
	input  logic              clk,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	sqrt_st_t st_q [SQ_STAGES];
	sqrt_st_t init;

	function automatic sqrt_st_t sqrt_step(sqrt_st_t a);
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		sqrt_st_t r;
		cur   = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
		trial = {{(REM_W-ROOT_W-2){1'b0}}, a.root, 2'b01};
		r.rad = {a.rad[RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	assign init = '{rad: rad, rem: '0, root: '0};

	always_ff @(posedge clk) begin
		st_q[0] <= sqrt_step(init);
		for (int k = 1; k < SQ_STAGES; k++) begin
			st_q[k] <= sqrt_step(st_q[k-1]);
		end
	end

	assign root = st_q[SQ_STAGES-1].root;

endmodule

### rtl/dbc_div.sv
module dbc_div
	import dbc_pkg::*;
(
	input  logic            clk,
	input  logic [NM_W-1:0] num,
	input  logic [D_W-1:0]  den,
	output logic [Q_W-1:0]  quo
);

	div_st_t st_q [DIV_STAGES];
	div_st_t init;

	function automatic div_st_t div_step(div_st_t a);
		logic [DREM_W-1:0] cur;
		div_st_t r;
		cur   = {a.rem[DREM_W-2:0], a.num[Q_W-1]};
		r.num = {a.num[Q_W-2:0], 1'b0};
		r.den = a.den;
		if (cur >= {1'b0, a.den}) begin
			r.rem = cur - {1'b0, a.den};
			r.quo = {a.quo[Q_W-2:0], 1'b1};
		end else begin
			r.rem = cur;
			r.quo = {a.quo[Q_W-2:0], 1'b0};
		end
		return r;
	endfunction

	assign init = '{
		num: {num[PRE_SH-1:0], {FRAC_W{1'b0}}},
		rem: {{(DREM_W-(NM_W-PRE_SH)){1'b0}}, num[NM_W-1:PRE_SH]},
		quo: '0,
		den: den
	};

	always_ff @(posedge clk) begin
		st_q[0] <= div_step(init);
		for (int k = 1; k < DIV_STAGES; k++) begin
			st_q[k] <= div_step(st_q[k-1]);
		end
	end

	assign quo = st_q[DIV_STAGES-1].quo;

endmodule

### rtl/dbc_sq.sv
module dbc_sq
	import dbc_pkg::*;
(
	input  logic             clk,
	input  logic [MAG_W-1:0] mag,
	output logic [VAL_W-1:0] sq
);

	logic                 sat_s1;
	logic [2*MH_W-1:0]    hh_s1;
	logic [MH_W+ML_W-1:0] hl_s1;
	logic [2*ML_W-1:0]    ll_s1;
	logic [PSUM_W-1:0]    psum;
	logic [MH_W-1:0]      mh;
	logic [ML_W-1:0]      ml;

	assign mh = mag[SAT_LSB-1:ML_W];
	assign ml = mag[ML_W-1:0];

	always_ff @(posedge clk) begin
		sat_s1 <= |mag[MAG_W-1:SAT_LSB];
		hh_s1  <= mh * mh;
		hl_s1  <= mh * ml;
		ll_s1  <= ml * ml;
	end

	assign psum = {hh_s1, {(2*ML_W){1'b0}}}
		+ {{(PSUM_W-MH_W-ML_W-ML_W-1){1'b0}}, hl_s1, {(ML_W+1){1'b0}}}
		+ {{(PSUM_W-2*ML_W){1'b0}}, ll_s1};

	always_ff @(posedge clk) begin
		sq <= sat_s1 ? VAL_CAP : psum[PSUM_W-1:FRAC_W];
	end

endmodule

### rtl/dalitz_boundary_check_core.sv
// Dalitz-plot boundary check, fully pipelined.
// A result for each accepted item is strobed on done; its path runs through two 45-stage
// root units and one 52-stage divider in series, plus the squarers.
// Throughput: one item per cycle; busy stays low.
// Reset: arst_n clears the valid pipeline and loads the default masses.
// The receiver cannot stall; results are shown for one cycle only.
module dalitz_boundary_check_core
	import dbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_W-1:0]    mass_sq_ab,
	input  logic [WORD_W-1:0]    mass_sq_ac,
	output logic                 done,
	output logic                 inside_region,
	output logic                 first_in_range,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic [WORD_W-1:0] parent_q, ma_q, mb_q, mc_q;
	logic [SQM_W-1:0]  m2_q, ma2_q, mb2_q, mc2_q, xmax_q;
	logic [XMIN_W-1:0] xmin_q;
	logic [SUM4_W-1:0] sum4_q;
	logic [WORD_W-1:0] dm;
	logic [WORD_W:0]   mab;
	logic [2*WORD_W-1:0]   p_m, p_a, p_b, p_c, p_x;
	logic [2*WORD_W+1:0]   p_n;

	logic                vld_s1;
	logic [WORD_W-1:0]   x_s1, y_s1;
	logic                vld_q [I_S6+1];
	side_t               side_q [I_S6+1];
	logic [RAD_W-1:0]    radx_s2;
	logic [XY_W-1:0]     xy_s2;
	nmag_t               nm_s2;
	nmag_t               nm_q [SQ_STAGES];
	logic signed [S_W-1:0] s_q [I_S6];
	logic signed [NB_W-1:0] nb_full, nc_full;
	logic                first_c;

	logic [ROOT_W-1:0]   rootx;
	logic [D_W-1:0]      den;
	logic [Q_W-1:0]      qb, qc;
	logic signed [MAG_W:0] eb_ext, ec_ext, esum;
	logic [MAG_W-1:0]    em_s3;
	logic [MAG_W-1:0]    em_q [EM_LEN];
	logic [VAL_W-1:0]    sqb, sqc;
	logic signed [Y_W-1:0] pb2, pc2;
	logic [RAD_W-1:0]    radb_s4, radc_s4;
	flag_t               fl_s4;
	flag_t               fl_q [SQ_STAGES];
	logic [ROOT_W-1:0]   rootb, rootc;
	logic [PB_W-1:0]     pb, pc;
	logic [MAG_W-1:0]    dmag_s5, smag_s5, emag_s5;
	logic                ok_q [SQR_STAGES+1];
	logic [VAL_W-1:0]    e2, dm2, sm2;
	logic signed [Y_W-1:0] yhi_s6, ylo_s6, s_ext;
	logic                ok_s6;
	logic                done_q, inside_q, first_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent_q <= RST_PARENT;
			ma_q     <= RST_MASS_A;
			mb_q     <= RST_MASS_B;
			mc_q     <= RST_MASS_C;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PARENT: parent_q <= cfg_data;
				REG_MASS_A: ma_q     <= cfg_data;
				REG_MASS_B: mb_q     <= cfg_data;
				REG_MASS_C: mc_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dm  = (parent_q >= mc_q) ? parent_q - mc_q : mc_q - parent_q;
	assign mab = {1'b0, ma_q} + {1'b0, mb_q};
	assign p_m = parent_q * parent_q;
	assign p_a = ma_q * ma_q;
	assign p_b = mb_q * mb_q;
	assign p_c = mc_q * mc_q;
	assign p_x = dm * dm;
	assign p_n = mab * mab;

	always_ff @(posedge clk) begin
		m2_q   <= p_m[2*WORD_W-1:FRAC_W];
		ma2_q  <= p_a[2*WORD_W-1:FRAC_W];
		mb2_q  <= p_b[2*WORD_W-1:FRAC_W];
		mc2_q  <= p_c[2*WORD_W-1:FRAC_W];
		xmax_q <= p_x[2*WORD_W-1:FRAC_W];
		xmin_q <= p_n[2*WORD_W+1:FRAC_W];
		sum4_q <= {2'b00, m2_q} + {2'b00, ma2_q} + {2'b00, mb2_q} + {2'b00, mc2_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
			for (int k = 0; k <= I_S6; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			vld_s1   <= start && !busy;
			vld_q[0] <= vld_s1;
			for (int k = 1; k <= I_S6; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
			done_q <= vld_q[I_S6];
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= mass_sq_ab;
		y_s1 <= mass_sq_ac;
	end

	assign first_c = ({{(XMIN_W-WORD_W){1'b0}}, x_s1} >= xmin_q)
		&& ({{(SQM_W-WORD_W){1'b0}}, x_s1} <= xmax_q);
	assign nb_full = $signed({{(NB_W-WORD_W){1'b0}}, x_s1})
		- $signed({{(NB_W-SQM_W){1'b0}}, ma2_q})
		+ $signed({{(NB_W-SQM_W){1'b0}}, mb2_q});
	assign nc_full = $signed({{(NB_W-SQM_W){1'b0}}, m2_q})
		- $signed({{(NB_W-WORD_W){1'b0}}, x_s1})
		- $signed({{(NB_W-SQM_W){1'b0}}, mc2_q});

	always_ff @(posedge clk) begin
		side_q[0] <= '{
			first: first_c,
			go:    first_c && (x_s1 != '0),
			sgn_b: nb_full[NB_W-1],
			sgn_c: nc_full[NB_W-1]
		};
		for (int k = 1; k <= I_S6; k++) begin
			side_q[k] <= side_q[k-1];
		end
		radx_s2  <= {{(RAD_W-WORD_W-FRAC_W){1'b0}}, x_s1, {FRAC_W{1'b1}}};
		xy_s2    <= {1'b0, x_s1} + {1'b0, y_s1};
		nm_s2.nb <= nb_full[NB_W-1] ? NM_W'(-nb_full) : nb_full[NM_W-1:0];
		nm_s2.nc <= nc_full[NB_W-1] ? NM_W'(-nc_full) : nc_full[NM_W-1:0];
		nm_q[0]  <= nm_s2;
		for (int k = 1; k < SQ_STAGES; k++) begin
			nm_q[k] <= nm_q[k-1];
		end
		s_q[0] <= $signed({{(S_W-SUM4_W){1'b0}}, sum4_q})
			- $signed({{(S_W-XY_W){1'b0}}, xy_s2});
		for (int k = 1; k < I_S6; k++) begin
			s_q[k] <= s_q[k-1];
		end
	end

	dbc_sqrt u_sqrt_x (
		.clk  (clk),
		.rad  (radx_s2),
		.root (rootx)
	);

	assign den = {rootx[D_W-2:0], 1'b0};

	dbc_div u_div_b (
		.clk (clk),
		.num (nm_q[SQ_STAGES-1].nb),
		.den (den),
		.quo (qb)
	);

	dbc_div u_div_c (
		.clk (clk),
		.num (nm_q[SQ_STAGES-1].nc),
		.den (den),
		.quo (qc)
	);

	assign eb_ext = side_q[I_DIV_OUT].sgn_b ? -$signed({2'b00, qb}) : $signed({2'b00, qb});
	assign ec_ext = side_q[I_DIV_OUT].sgn_c ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
	assign esum   = eb_ext + ec_ext;

	dbc_sq u_sq_b (
		.clk (clk),
		.mag ({1'b0, qb}),
		.sq  (sqb)
	);

	dbc_sq u_sq_c (
		.clk (clk),
		.mag ({1'b0, qc}),
		.sq  (sqc)
	);

	assign pb2 = $signed({1'b0, sqb}) - $signed({{(Y_W-SQM_W){1'b0}}, mb2_q});
	assign pc2 = $signed({1'b0, sqc}) - $signed({{(Y_W-SQM_W){1'b0}}, mc2_q});

	always_ff @(posedge clk) begin
		em_s3 <= esum[MAG_W] ? MAG_W'(-esum) : esum[MAG_W-1:0];
		em_q[0] <= em_s3;
		for (int k = 1; k < EM_LEN; k++) begin
			em_q[k] <= em_q[k-1];
		end
		radb_s4   <= {pb2[VAL_W-1:0], {FRAC_W{1'b1}}};
		radc_s4   <= {pc2[VAL_W-1:0], {FRAC_W{1'b1}}};
		fl_s4.ok  <= !pb2[Y_W-1] && !pc2[Y_W-1];
		fl_s4.cap_b <= !pb2[Y_W-1] && (pb2[VAL_W-1:0] == VAL_CAP);
		fl_s4.cap_c <= !pc2[Y_W-1] && (pc2[VAL_W-1:0] == VAL_CAP);
		fl_q[0] <= fl_s4;
		for (int k = 1; k < SQ_STAGES; k++) begin
			fl_q[k] <= fl_q[k-1];
		end
	end

	dbc_sqrt u_sqrt_b (
		.clk  (clk),
		.rad  (radb_s4),
		.root (rootb)
	);

	dbc_sqrt u_sqrt_c (
		.clk  (clk),
		.rad  (radc_s4),
		.root (rootc)
	);

	assign pb = fl_q[SQ_STAGES-1].cap_b ? ROOT_CAP : {{(PB_W-ROOT_W){1'b0}}, rootb};
	assign pc = fl_q[SQ_STAGES-1].cap_c ? ROOT_CAP : {{(PB_W-ROOT_W){1'b0}}, rootc};

	always_ff @(posedge clk) begin
		dmag_s5 <= (pb >= pc) ? {1'b0, pb - pc} : {1'b0, pc - pb};
		smag_s5 <= {1'b0, pb} + {1'b0, pc};
		emag_s5 <= em_q[EM_LEN-1];
		ok_q[0] <= fl_q[SQ_STAGES-1].ok;
		for (int k = 1; k <= SQR_STAGES; k++) begin
			ok_q[k] <= ok_q[k-1];
		end
	end

	dbc_sq u_sq_e (
		.clk (clk),
		.mag (emag_s5),
		.sq  (e2)
	);

	dbc_sq u_sq_d (
		.clk (clk),
		.mag (dmag_s5),
		.sq  (dm2)
	);

	dbc_sq u_sq_s (
		.clk (clk),
		.mag (smag_s5),
		.sq  (sm2)
	);

	always_ff @(posedge clk) begin
		yhi_s6 <= $signed({1'b0, e2}) - $signed({1'b0, dm2});
		ylo_s6 <= $signed({1'b0, e2}) - $signed({1'b0, sm2});
		ok_s6  <= ok_q[SQR_STAGES];
	end

	assign s_ext = {{(Y_W-S_W){s_q[I_S6-1][S_W-1]}}, s_q[I_S6-1]};

	always_ff @(posedge clk) begin
		inside_q <= side_q[I_S6].go && ok_s6 && (ylo_s6 <= s_ext) && (s_ext <= yhi_s6);
		first_q  <= side_q[I_S6].first;
	end

	assign done           = done_q;
	assign inside_region  = inside_q;
	assign first_in_range = first_q;

endmodule
